[hdl/rmd320_pkg.sv]
// Constants, tables and functions shared by the RIPEMD-320 hash modules.
package rmd320_pkg;

  typedef logic [31:0] word_t;

  localparam int NumChain = 10;

  // Controls handed from the sequencer to the round unit.
  typedef struct packed {
    logic       load;   // copy chaining words into the working registers
    logic       step;   // run one round step
    logic [6:0] rnd;    // step number 0..79
    logic       fold;   // add working words into the chaining words
    logic       init;   // return chaining words to their initial values
  } rnd_ctl_t;

  function automatic word_t init_chain(input logic [3:0] i);
    case (i)
      4'd0: init_chain = 32'h67452301;
      4'd1: init_chain = 32'hEFCDAB89;
      4'd2: init_chain = 32'h98BADCFE;
      4'd3: init_chain = 32'h10325476;
      4'd4: init_chain = 32'hC3D2E1F0;
      4'd5: init_chain = 32'h76543210;
      4'd6: init_chain = 32'hFEDCBA98;
      4'd7: init_chain = 32'h89ABCDEF;
      4'd8: init_chain = 32'h01234567;
      4'd9: init_chain = 32'h3C2D1E0F;
      default: init_chain = 32'h0;
    endcase
  endfunction

  localparam logic [3:0] SEL_L [80] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
    7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
    1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
  localparam logic [3:0] SEL_R [80] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
    6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
    8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
  localparam logic [4:0] ROT_L [80] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
    7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
    11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
  localparam logic [4:0] ROT_R [80] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
    9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
    15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
  localparam word_t ADD_L [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
                                  32'h8F1BBCDC, 32'hA953FD4E};
  localparam word_t ADD_R [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                  32'h7A6D76E9, 32'h00000000};

  function automatic word_t rol(input word_t x, input logic [4:0] n);
    rol = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic word_t mix(input logic [2:0] k, input word_t x, input word_t y,
                                input word_t z);
    case (k)
      3'd0: mix = x ^ y ^ z;
      3'd1: mix = (x & y) | (~x & z);
      3'd2: mix = (x | ~y) ^ z;
      3'd3: mix = (x & z) | (y & ~z);
      default: mix = x ^ (y | ~z);
    endcase
  endfunction

endpackage

[hdl/rmd320_if.sv]
// Valid/ready channel interfaces for message words and digest words.
interface rmd320_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  bytes_valid;
  logic        last;
  modport source (output valid, data_word, bytes_valid, last, input ready);
  modport sink (input valid, data_word, bytes_valid, last, output ready);
endinterface

interface rmd320_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [3:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

[hdl/rmd320_round.sv]
// Shared round unit: working registers, chaining words and the two-line step logic.
module rmd320_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmd320_pkg::rnd_ctl_t  ctl,
  input  rmd320_pkg::word_t     blk_l,
  input  rmd320_pkg::word_t     blk_r,
  input  logic [3:0]            rd_idx,
  output rmd320_pkg::word_t     chain_word
);

  rmd320_pkg::word_t w_r [10];
  rmd320_pkg::word_t chain_r [10];
  rmd320_pkg::word_t tl, tr;
  rmd320_pkg::word_t wn [10];
  logic [2:0] rd;

  always_comb begin
    rd = ctl.rnd[6:4];
    tl = rmd320_pkg::rol(w_r[0] + rmd320_pkg::mix(rd, w_r[1], w_r[2], w_r[3]) + blk_l
           + rmd320_pkg::ADD_L[rd], rmd320_pkg::ROT_L[ctl.rnd]) + w_r[4];
    tr = rmd320_pkg::rol(w_r[5] + rmd320_pkg::mix(3'd4 - rd, w_r[6], w_r[7], w_r[8]) + blk_r
           + rmd320_pkg::ADD_R[rd], rmd320_pkg::ROT_R[ctl.rnd]) + w_r[9];
    wn[0] = w_r[4]; wn[4] = w_r[3]; wn[3] = rmd320_pkg::rol(w_r[2], 5'd10);
    wn[2] = w_r[1]; wn[1] = tl;
    wn[5] = w_r[9]; wn[9] = w_r[8]; wn[8] = rmd320_pkg::rol(w_r[7], 5'd10);
    wn[7] = w_r[6]; wn[6] = tr;
    // Last step of each round swaps one register between the lines: B, D, A, C, E.
    if (ctl.rnd[3:0] == 4'hF) begin
      case (rd)
        3'd0: begin wn[1] = tr; wn[6] = tl; end
        3'd1: begin
          wn[3] = rmd320_pkg::rol(w_r[7], 5'd10);
          wn[8] = rmd320_pkg::rol(w_r[2], 5'd10);
        end
        3'd2: begin wn[0] = w_r[9]; wn[5] = w_r[4]; end
        3'd3: begin wn[2] = w_r[6]; wn[7] = w_r[1]; end
        default: begin wn[4] = w_r[8]; wn[9] = w_r[3]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 10; i++) w_r[i] <= chain_r[i];
    end else if (ctl.step) begin
      for (int i = 0; i < 10; i++) w_r[i] <= wn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 10; i++) chain_r[i] <= rmd320_pkg::init_chain(4'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 10; i++) chain_r[i] <= chain_r[i] + w_r[i];
    end
  end

  assign chain_word = (rd_idx < 4'd10) ? chain_r[rd_idx] : '0;

endmodule

[hdl/ripemd320_hash.sv]
// Top level of the RIPEMD-320 hash: word intake, padding, sequencer and digest output.
//
// Usage: message words enter on in_ (data_word little-endian, bytes_valid, last).
// A word that does not complete a 16-word block is stored, and in_ready stays high. A word
// that completes a block starts a compression of 80 steps, one step per cycle
// in the shared round unit, plus a load and a fold state; in_ready is low
// meanwhile. On the last word the block appends the 0x80 byte, zeros and the
// 64-bit bit length, one pad word per cycle, compressing once or twice as
// needed, then presents the ten digest words H0..H9 on out_, one per beat,
// digest_last on the tenth. A stalled receiver holds the current digest word;
// no new input is taken until all ten beats are delivered, after which all
// state returns to the reset values for the next message. The synchronous
// active-low reset clears the length, word count and sequencer and loads the
// initial chaining words; the block words need no reset.
module ripemd320_hash (
  input logic        clk,
  input logic        rst_n,
  rmd320_in_if.sink  in_ch,
  rmd320_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_RUN  = 6'b000100,
    S_FOLD = 6'b001000,
    S_PAD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  rmd320_pkg::word_t blk_r [16];
  logic [3:0]  cnt_r;
  logic [60:0] len_r;
  logic [6:0]  rnd_r;
  logic        pad_r;   // message ended, padding in progress
  logic [3:0]  oidx_r;
  logic        full4_r;   // last word had four bytes: the 0x80 word is still due
  logic        len_ok_r;  // the current block has room for the length words
  rmd320_pkg::rnd_ctl_t ctl;
  rmd320_pkg::word_t chain_word, pad_word, pad_sel, wr_word;
  logic        wr_en, acc;
  logic [2:0]  nb;
  logic [63:0] bits;
  logic [60:0] len_add;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign nb = !in_ch.last ? 3'd4 : (in_ch.bytes_valid > 3'd4 ? 3'd4 : in_ch.bytes_valid);
  assign len_add = len_r + 61'(nb);
  assign bits = {len_r, 3'b000};

  // Word written on a last beat: masked data with the 0x80 byte after it.
  function automatic rmd320_pkg::word_t tail(input rmd320_pkg::word_t d, input logic [2:0] n);
    case (n)
      3'd0: tail = 32'h00000080;
      3'd1: tail = {16'h0, 8'h80, d[7:0]};
      3'd2: tail = {8'h0, 8'h80, d[15:0]};
      3'd3: tail = {8'h80, d[23:0]};
      default: tail = d;
    endcase
  endfunction

  // Pad words: zeros, with the low and high length words in words 14 and 15.
  always_comb begin
    if (cnt_r == 4'd14) pad_word = bits[31:0];
    else if (cnt_r == 4'd15) pad_word = bits[63:32];
    else pad_word = '0;
  end

  // Length words only go in once no 0x80 word is pending and the block has room.
  always_comb begin
    if (full4_r) pad_sel = 32'h00000080;
    else if (len_ok_r) pad_sel = pad_word;
    else pad_sel = '0;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_word = pad_sel;
    if (acc) begin
      wr_en = 1'b1;
      wr_word = in_ch.last ? tail(in_ch.data_word, nb) : in_ch.data_word;
    end else if (state_r == S_PAD) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) blk_r[cnt_r] <= wr_word;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc) begin
        if (cnt_r == 4'd15) state_nxt = S_LOAD;
        else if (in_ch.last) state_nxt = S_PAD;
      end
      S_LOAD: state_nxt = S_RUN;
      S_RUN:  if (rnd_r == 7'd79) state_nxt = S_FOLD;
      S_FOLD: begin
        if (!pad_r) state_nxt = S_IDLE;
        else if (cnt_r == 4'd0 && !full4_r && oidx_r == 4'd1) state_nxt = S_OUT;
        else state_nxt = S_PAD;
      end
      S_PAD:  if (cnt_r == 4'd15) state_nxt = S_LOAD;
      S_OUT:  if (out_ch.ready && oidx_r == 4'd9) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // oidx_r doubles as a "length words written" flag during padding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      len_r    <= '0;
      rnd_r    <= '0;
      pad_r    <= 1'b0;
      full4_r  <= 1'b0;
      len_ok_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) cnt_r <= cnt_r + 4'd1;
      if (acc) begin
        len_r <= len_add;
        pad_r <= in_ch.last;
        full4_r <= in_ch.last && nb == 3'd4;
        // The 0x80 byte lands in this word; the length fits if two words remain.
        if (in_ch.last && nb != 3'd4 && cnt_r < 4'd14) len_ok_r <= 1'b1;
      end
      if (state_r == S_PAD) begin
        // First pad word after a full last word carries the 0x80 byte.
        if (full4_r) begin
          full4_r <= 1'b0;
          if (cnt_r < 4'd14) len_ok_r <= 1'b1;
        end
        if (cnt_r == 4'd15 && !full4_r && len_ok_r) oidx_r <= 4'd1;
      end
      if (state_r == S_FOLD && pad_r) len_ok_r <= 1'b1;
      if (state_r == S_RUN) rnd_r <= (rnd_r == 7'd79) ? 7'd0 : rnd_r + 7'd1;
      if (state_r == S_FOLD && state_nxt == S_OUT) oidx_r <= '0;
      if (state_r == S_OUT && out_ch.ready) begin
        if (oidx_r == 4'd9) begin
          oidx_r   <= '0;
          len_r    <= '0;
          pad_r    <= 1'b0;
          len_ok_r <= 1'b0;
        end else begin
          oidx_r <= oidx_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    ctl.load = (state_r == S_LOAD);
    ctl.step = (state_r == S_RUN);
    ctl.rnd  = rnd_r;
    ctl.fold = (state_r == S_FOLD);
    ctl.init = (state_r == S_OUT) && out_ch.ready && (oidx_r == 4'd9);
  end

  rmd320_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .blk_l(blk_r[rmd320_pkg::SEL_L[rnd_r]]),
    .blk_r(blk_r[rmd320_pkg::SEL_R[rnd_r]]),
    .rd_idx(oidx_r), .chain_word(chain_word)
  );

  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = chain_word;
  assign out_ch.word_index  = oidx_r;
  assign out_ch.digest_last = (oidx_r == 4'd9);

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> (rnd_r == 7'd0)) else $error("step count not cleared");
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (state_r == S_RUN)) else $error("load not followed by run");
  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (oidx_r < 4'd10)) else $error("digest index out of range");
`endif

endmodule
